FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside of reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check an implication in the next cycle, outside of reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/gstg_pkg.sv
package gstg_pkg;

  // Sine table geometry: the full turn has 2^SineTableBits steps, the stored
  // quarter wave has QuarterSize + 1 entries (both ends included).
  localparam int SineTableBits = 10;
  localparam int QuarterBits   = SineTableBits - 2;
  localparam int QuarterSize   = 1 << QuarterBits;
  localparam int TabIdxW       = QuarterBits + 1;

  localparam int PhaseW   = 32;
  localparam int CounterW = 25;
  localparam int HalfW    = 24;
  localparam int GainW    = 8;
  localparam int MagW     = 15;
  localparam int AmpW     = 15;
  localparam int SampleW  = 16;

  localparam logic [GainW-1:0] GainMax    = 8'd200;
  localparam logic [AmpW-1:0]  AmpPerGain = 15'd100;

  // Register indexes on the configuration port.
  localparam logic RegPhaseStep  = 1'b0;
  localparam logic RegHalfPeriod = 1'b1;

  // Quarter-wave polynomial constants, Q30.
  localparam logic [63:0] Q30One = 64'd1073741824;
  localparam logic [63:0] PolyA  = 64'd1686629713;
  localparam logic [63:0] PolyB  = 64'd693598564;
  localparam logic [63:0] PolyC  = 64'd85569278;
  localparam logic [63:0] MagMax = 64'd32767;

  typedef logic [QuarterSize:0][MagW-1:0] sine_tab_t;

  // One sample in flight between the state update and the result register.
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [AmpW-1:0]   amp;
    logic              last;
  } stage_t;

  // Build the quarter-wave magnitude table at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t     tab;
    logic [63:0]   x;
    logic [63:0]   x2;
    logic [63:0]   t;
    logic [63:0]   y;
    for (int j = 0; j <= QuarterSize; j++) begin
      x = 64'(j) << (32 - SineTableBits);
      if (x > Q30One) x = Q30One;
      x2 = (x * x) >> 30;
      t  = (PolyC * x2) >> 30;
      t  = PolyB - t;
      t  = (t * x2) >> 30;
      t  = PolyA - t;
      y  = ((t * x) >> 30) >> 15;
      if (y > MagMax) y = MagMax;
      tab[j] = y[MagW-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTab = build_sine_tab();

endpackage

FILE: sv/gstg_sample.sv
module gstg_sample (
  input  gstg_pkg::stage_t                    stage_i,
  output logic signed [gstg_pkg::SampleW-1:0] sample_o
);

  logic [gstg_pkg::SineTableBits-1:0] tab_k;
  logic [1:0]                         quad;
  logic [gstg_pkg::QuarterBits-1:0]   quart_j;
  logic [gstg_pkg::TabIdxW-1:0]       tab_idx;
  logic [gstg_pkg::MagW-1:0]          mag;
  logic [gstg_pkg::MagW+gstg_pkg::AmpW-1:0] prod;
  logic [gstg_pkg::MagW-1:0]          scaled;
  logic                               neg;

  // Fold the phase into the first quadrant
  assign tab_k   = stage_i.phase[gstg_pkg::PhaseW-1 -: gstg_pkg::SineTableBits];
  assign quad    = tab_k[gstg_pkg::SineTableBits-1 -: 2];
  assign quart_j = tab_k[gstg_pkg::QuarterBits-1:0];
  assign tab_idx = quad[0]
                 ? gstg_pkg::TabIdxW'(gstg_pkg::QuarterSize) - gstg_pkg::TabIdxW'(quart_j)
                 : gstg_pkg::TabIdxW'(quart_j);

  // Look up the magnitude and scale by the gain
  assign mag    = gstg_pkg::SineTab[tab_idx];
  assign prod   = (gstg_pkg::MagW + gstg_pkg::AmpW)'(mag)
                * (gstg_pkg::MagW + gstg_pkg::AmpW)'(stage_i.amp);
  assign scaled = prod[gstg_pkg::MagW+gstg_pkg::AmpW-1 -: gstg_pkg::MagW];

  // Negate in the second half of the turn; a zero magnitude stays positive
  assign neg = quad[1] && (mag != '0);

  always_comb begin
    if (neg) begin
      sample_o = -$signed({1'b0, scaled});
    end else begin
      sample_o = $signed({1'b0, scaled});
    end
  end

endmodule

FILE: sv/gated_sine_tone_generator_unit.sv
// Gated sine tone generator: each accepted request item yields one stereo
// sample item, the same value on both channels. The block takes one item per
// clock cycle unless the output stalls; an accepted request passes through
// the stage register that holds the phase and gain of the sample, then the
// output register, which takes the result of the sine lookup and the gain
// multiply. The sine comes from a constant quarter-wave table of 257
// entries. Write phase_step (address 0) and half_period_samples (address 4)
// only while no item is in flight; writing the half period restarts the gate.
module gated_sine_tone_generator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                request_last_i,
  // Sample channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gstg_pkg::SampleW-1:0] left_sample_o,
  output logic signed [gstg_pkg::SampleW-1:0] right_sample_o,
  output logic                                frame_last_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [gstg_pkg::PhaseW-1:0]   phase_step_q;
  logic [gstg_pkg::HalfW-1:0]    half_period_q;
  logic [gstg_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic [gstg_pkg::CounterW-1:0] counter_q, counter_d, counter_inc;
  logic [gstg_pkg::GainW-1:0]    gain_q, gain_d;
  logic                          gate_on;
  logic                          cfg_write;
  logic                          in_accept;
  logic                          s1_advance;
  logic                          s1_valid_q;
  gstg_pkg::stage_t              s1_q, s1_d;
  logic signed [gstg_pkg::SampleW-1:0] sample;
  logic signed [gstg_pkg::SampleW-1:0] sample_q;
  logic                          last_q;
  logic                          out_valid_q;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      gstg_pkg::RegPhaseStep:  prdata = phase_step_q;
      gstg_pkg::RegHalfPeriod: prdata = 32'(half_period_q);
      default:                 prdata = '0;
    endcase
  end

  // Handshake: the stage moves on when the output register is free or drains
  assign s1_advance = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Gate and gain for the item being accepted
  assign gate_on = (half_period_q == '0) || (counter_q < gstg_pkg::CounterW'(half_period_q));

  always_comb begin
    gain_d = gain_q;
    if (gate_on) begin
      if (gain_q < gstg_pkg::GainMax) gain_d = gain_q + 1'b1;
    end else begin
      if (gain_q != '0) gain_d = gain_q - 1'b1;
    end
  end

  // Advance phase and gate counter
  assign phase_d     = phase_q + phase_step_q;
  assign counter_inc = counter_q + 1'b1;

  always_comb begin
    counter_d = counter_inc;
    if ((half_period_q != '0) && (counter_inc >= {half_period_q, 1'b0})) begin
      counter_d = '0;
    end
  end

  // Stage payload: old phase, amplitude from the new gain
  always_comb begin
    s1_d.phase = phase_q;
    s1_d.amp   = gstg_pkg::AmpW'(gain_d) * gstg_pkg::AmpPerGain;
    s1_d.last  = request_last_i;
  end

  // Hold configuration and tone state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= '0;
      half_period_q <= '0;
      phase_q       <= '0;
      counter_q     <= '0;
      gain_q        <= '0;
    end else begin
      if (in_accept) begin
        phase_q <= phase_d;
        gain_q  <= gain_d;
      end
      // A half-period write restarts the gate
      if (cfg_write && (paddr[2] == gstg_pkg::RegHalfPeriod)) begin
        counter_q <= '0;
      end else if (in_accept) begin
        counter_q <= counter_d;
      end
      if (cfg_write) begin
        unique case (paddr[2])
          gstg_pkg::RegPhaseStep: begin
            phase_step_q <= pwdata;
          end
          gstg_pkg::RegHalfPeriod: begin
            half_period_q <= pwdata[gstg_pkg::HalfW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Stage register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  // Sine lookup and gain scaling
  gstg_sample u_sample (
    .stage_i  (s1_q),
    .sample_o (sample)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      sample_q <= sample;
      last_q   <= s1_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = sample_q;
  assign right_sample_o = sample_q;
  assign frame_last_o   = last_q;

endmodule

FILE: sv/gstg_checker.sv
`include "assert_macros.svh"

module gstg_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [gstg_pkg::SampleW-1:0] left_sample_o,
  input logic signed [gstg_pkg::SampleW-1:0] right_sample_o
);

  // Both channels carry the same sample
  `ASSERT_IMPLY(a_channels_equal, clk_i, rst_ni, out_valid_o, left_sample_o == right_sample_o)

  // The sample never leaves the amplitude range of full gain
  `ASSERT_IMPLY(a_sample_range, clk_i, rst_ni, out_valid_o, (left_sample_o <= 16'sd20000) && (left_sample_o >= -16'sd20000))

  // An empty output register never backs up the request side
  `ASSERT_IMPLY(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o)

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(left_sample_o))

endmodule

bind gated_sine_tone_generator_unit gstg_checker u_gstg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .left_sample_o  (left_sample_o),
  .right_sample_o (right_sample_o)
);

FILE: tb/tb_gated_sine_tone_generator_unit.sv
module tb_gated_sine_tone_generator_unit;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          HOLD_CYCLES  = 120;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RANDOM_ITEMS = 1950;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [63:0] Q30_UNIT     = 64'd1073741824;
  localparam logic [63:0] COEF_A       = 64'd1686629713;
  localparam logic [63:0] COEF_B       = 64'd693598564;
  localparam logic [63:0] COEF_C       = 64'd85569278;
  localparam logic [63:0] MAG_LIMIT    = 64'd32767;
  localparam logic [7:0]  GAIN_TOP     = 8'd200;
  localparam logic [31:0] AMP_STEP     = 32'd100;
  localparam logic [24:0] CNT_MASK     = 25'h1FFFFFF;

  typedef struct {
    logic signed [gstg_pkg::SampleW-1:0] left;
    logic signed [gstg_pkg::SampleW-1:0] right;
    logic                                last;
  } stereo_t;

  // Predicts one stereo sample per request and matches them against the block
  class sample_scoreboard;
    logic [31:0] step_reg;
    logic [23:0] half_reg;
    logic [31:0] phase_acc;
    logic [24:0] gate_cnt;
    logic [7:0]  gain;
    stereo_t     pending_samples[$];
    int          errors;

    function void clear_state();
      step_reg  = '0;
      half_reg  = '0;
      phase_acc = '0;
      gate_cnt  = '0;
      gain      = '0;
      pending_samples.delete();
      errors    = 0;
    endfunction

    function void flag(string what, longint expv, longint actv);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch %0d: %s expected %0d got %0d", errors, what, expv, actv);
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == gstg_pkg::RegPhaseStep) begin
        step_reg = value;
      end else begin
        half_reg = value[23:0];
        gate_cnt = '0;
      end
    endfunction

    // Sine of the phase (quarter-wave polynomial, Q1.15) scaled by 100 * gain
    function logic signed [gstg_pkg::SampleW-1:0] predict_sample(logic [31:0] ph,
                                                                logic [7:0] g);
      logic [9:0]  k;
      logic [8:0]  j;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] y;
      logic [31:0] scaled;
      k = ph[31:22];
      j = {1'b0, k[7:0]};
      if (k[8]) j = 9'd256 - j;
      x = 64'(j) << 22;
      if (x > Q30_UNIT) x = Q30_UNIT;
      x2 = (x * x) >> 30;
      t  = (COEF_C * x2) >> 30;
      t  = COEF_B - t;
      t  = (t * x2) >> 30;
      t  = COEF_A - t;
      y  = ((t * x) >> 30) >> 15;
      if (y > MAG_LIMIT) y = MAG_LIMIT;
      scaled = (y[31:0] * AMP_STEP * {24'd0, g}) >> 15;
      if (k[9] && y != 0)
        return -$signed(scaled[15:0]);
      return $signed(scaled[15:0]);
    endfunction

    // Advance gate, gain, phase and counter for one accepted request
    function void note_request(logic last);
      stereo_t     s;
      logic        gate_on;
      logic [24:0] nxt;
      gate_on = (half_reg == 0) || (gate_cnt < {1'b0, half_reg});
      if (gate_on) begin
        if (gain < GAIN_TOP) gain++;
      end else begin
        if (gain > 0) gain--;
      end
      s.left  = predict_sample(phase_acc, gain);
      s.right = s.left;
      s.last  = last;
      pending_samples.push_back(s);
      phase_acc = phase_acc + step_reg;
      nxt = (gate_cnt + 25'd1) & CNT_MASK;
      if (half_reg != 0 && {1'b0, nxt} >= {2'b0, half_reg} << 1) nxt = '0;
      gate_cnt = nxt;
    endfunction

    function void check_sample(logic signed [gstg_pkg::SampleW-1:0] l,
                               logic signed [gstg_pkg::SampleW-1:0] r,
                               logic last);
      stereo_t e;
      if (pending_samples.size() == 0) begin
        flag("unexpected sample, left", 0, l);
        return;
      end
      e = pending_samples.pop_front();
      if (l !== e.left) flag("left_sample", e.left, l);
      if (r !== e.right) flag("right_sample", e.right, r);
      if (last !== e.last) flag("frame_last", e.last, last);
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_stall_o;
  logic                                request_last_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i    = 1'b0;
  logic signed [gstg_pkg::SampleW-1:0] left_sample_o;
  logic signed [gstg_pkg::SampleW-1:0] right_sample_o;
  logic                                frame_last_o;
  logic                                psel           = 1'b0;
  logic                                penable        = 1'b0;
  logic                                pwrite         = 1'b0;
  logic [2:0]                          paddr          = '0;
  logic [31:0]                         pwdata         = '0;
  logic [31:0]                         prdata;
  logic                                pready;

  sample_scoreboard sb = new();
  bit               quiet;
  int               holds_requested;
  int               holds_taken;
  int               hold_left;
  int               cycles;
  int               sent;

  gated_sine_tone_generator_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[gated_sine_tone_generator_unit] ERROR");
      $finish;
    end
  end

  // Check accepted samples, then pick the stall for the next cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      holds_taken <= 0;
    end else begin
      if (out_valid_o && !out_stall_i)
        sb.check_sample(left_sample_o, right_sample_o, frame_last_o);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (holds_taken != holds_requested) begin
        out_stall_i <= 1'b1;
        hold_left   <= HOLD_CYCLES - 1;
        holds_taken <= holds_taken + 1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < 9);
      end
    end
  end

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic cfg_readback(input logic idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) sb.flag("register readback", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write the selected registers (both, one or neither) and read them back
  task automatic configure(input logic [31:0] step, input logic [31:0] half,
                           input bit write_step, input bit write_half);
    if (write_step) begin
      cfg_write(gstg_pkg::RegPhaseStep, step);
      cfg_readback(gstg_pkg::RegPhaseStep, step);
    end
    if (write_half) begin
      cfg_write(gstg_pkg::RegHalfPeriod, half);
      cfg_readback(gstg_pkg::RegHalfPeriod, {8'd0, half[23:0]});
    end
  endtask

  task automatic send_request(input logic last);
    if (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    request_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(last);
    sent++;
  endtask

  // Drop valid and hold off until every expected sample has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic run_burst(input int count);
    for (int i = 0; i < count; i++)
      send_request($urandom_range(0, 7) == 0);
    drain();
  endtask

  initial begin
    logic [31:0] step;
    logic [31:0] half;
    int          phase_no;
    int          burst;
    sb.clear_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers come out of reset cleared
    cfg_readback(gstg_pkg::RegPhaseStep, '0);
    cfg_readback(gstg_pkg::RegHalfPeriod, '0);

    // Directed: silent tone, quarter-turn steps with a short gate, extreme settings
    send_request(1'b1);
    send_request(1'b0);
    drain();
    configure(32'h4000_0000, 32'd3, 1'b1, 1'b1);
    for (int i = 0; i < 8; i++) send_request(i[0]);
    drain();
    configure(32'h8000_0000, 32'h00FF_FFFF, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) send_request(i == 5);
    drain();
    configure(32'hFFFF_FFFF, 32'hFF00_0000, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) send_request(i[1]);
    drain();

    // Random bursts, each preceded by rewriting a random subset of the registers
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: step = $urandom();
        1: step = $urandom_range(0, 32'h0040_0000);
        2: step = {10'($urandom_range(0, 1023)), 22'd0};
        default: step = $urandom_range(0, 1) ? 32'h8000_0000 : 32'd0;
      endcase
      case ($urandom_range(0, 3))
        0: half = 32'd0;
        1: half = $urandom_range(1, 300);
        2: half = $urandom();
        default: half = 32'h00FF_FFFF;
      endcase
      configure(step, half, phase_no == 0 || $urandom_range(0, 3) != 0,
                phase_no == 0 || $urandom_range(0, 3) != 0);
      if (phase_no == 2) holds_requested++;
      quiet = (phase_no == 4);
      burst = $urandom_range(60, 300);
      if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
      run_burst(burst);
      quiet = 1'b0;
      phase_no++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[gated_sine_tone_generator_unit] OK");
    end else begin
      $display("[gated_sine_tone_generator_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/gstg_pkg.sv
sv/gstg_sample.sv
sv/gated_sine_tone_generator_unit.sv
sv/gstg_checker.sv
tb/tb_gated_sine_tone_generator_unit.sv
